// ===== design/lcdbp_pkg.sv =====
package lcdbp_pkg;

	typedef enum logic [2:0] {
		KIND_CHAR   = 3'd0,
		KIND_CLEAR  = 3'd1,
		KIND_HOME   = 3'd2,
		KIND_CURSOR = 3'd3,
		KIND_OTHER  = 3'd4
	} kind_t;

	localparam int unsigned ADDR_W = 7;

	localparam logic [1:0] REG_ROW_ONE_BASE   = 2'd0;
	localparam logic [1:0] REG_ROW_TWO_BASE   = 2'd1;
	localparam logic [1:0] REG_ROW_THREE_BASE = 2'd2;

	localparam logic [ADDR_W-1:0] ROW_ONE_BASE_RST   = 7'd64;
	localparam logic [ADDR_W-1:0] ROW_TWO_BASE_RST   = 7'd20;
	localparam logic [ADDR_W-1:0] ROW_THREE_BASE_RST = 7'd84;

	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_HOME       = 8'h02;
	localparam logic [7:0] PRINT_LO       = 8'h20;
	localparam logic [7:0] PRINT_HI       = 8'h7E;
	localparam logic [6:0] QMARK          = 7'h3F;

	localparam int unsigned EN_BIT  = 2;
	localparam int unsigned SEL_BIT = 0;

	typedef struct packed {
		logic [ADDR_W-1:0] row_one;
		logic [ADDR_W-1:0] row_two;
		logic [ADDR_W-1:0] row_three;
	} row_bases_t;

	typedef struct packed {
		kind_t             kind;
		logic [6:0]        shown_char;
		logic [1:0]        row;
		logic [ADDR_W-1:0] col;
	} result_t;

endpackage

// ===== design/lcdbp_classify.sv =====
module lcdbp_classify (
	input  logic [7:0]           value,
	input  logic                 sel,
	input  lcdbp_pkg::row_bases_t bases,
	output lcdbp_pkg::result_t    result
);
	import lcdbp_pkg::*;

	logic [ADDR_W-1:0] addr;

	assign addr = value[ADDR_W-1:0];

	always_comb begin
		result.kind       = KIND_OTHER;
		result.shown_char = '0;
		result.row        = '0;
		result.col        = '0;
		if (sel) begin
			result.kind = KIND_CHAR;
			if (value >= PRINT_LO && value <= PRINT_HI) begin
				result.shown_char = value[6:0];
			end else begin
				result.shown_char = QMARK;
			end
		end else if (value == CMD_CLEAR) begin
			result.kind = KIND_CLEAR;
		end else if (value == CMD_HOME) begin
			result.kind = KIND_HOME;
		end else if (value[7]) begin
			result.kind = KIND_CURSOR;
			if (addr >= bases.row_three) begin
				result.row = 2'd3;
				result.col = addr - bases.row_three;
			end else if (addr >= bases.row_one) begin
				result.row = 2'd1;
				result.col = addr - bases.row_one;
			end else if (addr >= bases.row_two) begin
				result.row = 2'd2;
				result.col = addr - bases.row_two;
			end else begin
				result.row = 2'd0;
				result.col = addr;
			end
		end
	end

endmodule

// ===== design/lcd_backpack_byte_decoder_unit.sv =====
// A byte that completes the second enable pulse is rebuilt into stage s1 and then
// registered into the output stage as a result beat; other bytes give no result.
// Throughput: one raw byte per cycle while in_stall is low, set by the single edge-tracking stage.
// Reset clears the nibble tracker, the pipeline valids and restores the row
// base registers to 64, 20 and 84.
module lcd_backpack_byte_decoder_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                raw_byte,
	output logic                      out_valid,
	input  logic                      out_stall,
	output lcdbp_pkg::kind_t          kind,
	output logic [7:0]                value,
	output logic [6:0]                shown_char,
	output logic [1:0]                row,
	output logic [6:0]                col,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [6:0]                cfg_data
);
	import lcdbp_pkg::*;

	row_bases_t bases_q;
	logic [3:0] high_q;
	logic [3:0] low_q;
	logic       sel_q;
	logic       done_q;
	logic       en_prev_q;

	logic       valid_s1;
	logic [7:0] value_s1;
	logic       sel_s1;

	logic       out_valid_q;
	logic [7:0] value_q;
	result_t    result_q;

	logic       in_fire;
	logic       en;
	logic       rise;
	logic       fall;
	logic       commit;
	logic       out_load;
	result_t    result;

	assign cfg_ready = 1'b1;

	assign en       = raw_byte[EN_BIT];
	assign rise     = !en_prev_q && en;
	assign fall     = en_prev_q && !en;
	assign commit   = in_fire && fall && done_q;
	assign out_load = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_load;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bases_q.row_one   <= ROW_ONE_BASE_RST;
			bases_q.row_two   <= ROW_TWO_BASE_RST;
			bases_q.row_three <= ROW_THREE_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW_ONE_BASE:   bases_q.row_one   <= cfg_data;
				REG_ROW_TWO_BASE:   bases_q.row_two   <= cfg_data;
				REG_ROW_THREE_BASE: bases_q.row_three <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q    <= '0;
			low_q     <= '0;
			sel_q     <= 1'b0;
			done_q    <= 1'b0;
			en_prev_q <= 1'b0;
		end else if (in_fire) begin
			en_prev_q <= en;
			if (rise) begin
				if (!done_q) begin
					high_q <= raw_byte[7:4];
				end else begin
					low_q <= raw_byte[7:4];
				end
				sel_q <= raw_byte[SEL_BIT];
			end else if (fall) begin
				done_q <= !done_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire || out_load) begin
			valid_s1 <= commit;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			value_s1 <= {high_q, low_q};
			sel_s1   <= sel_q;
		end
	end

	lcdbp_classify u_classify (
		.value  (value_s1),
		.sel    (sel_s1),
		.bases  (bases_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			value_q  <= value_s1;
			result_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = result_q.kind;
	assign value      = value_q;
	assign shown_char = result_q.shown_char;
	assign row        = result_q.row;
	assign col        = result_q.col;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with a free pipeline");

	a_s1_moves_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_load |=> out_valid_q)
		else $error("pending byte lost between stages");

	a_char_only_for_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind != KIND_CHAR |-> shown_char == '0)
		else $error("shown character set on a command");

	a_cursor_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind != KIND_CURSOR |-> row == '0 && col == '0)
		else $error("cursor position set on a non-cursor result");

	a_commit_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> !done_q)
		else $error("nibble counter not cleared after a rebuilt byte");

endmodule
